### rtl/core/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants of the LZSS stream decompressor: payload structs,
// configuration register indexes, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package lzss_pkg;

	// Field widths fixed by the compressed format
	localparam int BYTE_W      = 8;
	localparam int LEN_FIELD_W = 4;
	localparam int DIST_W      = 12;
	localparam int LEN_W       = 5;
	localparam int TOKEN_W     = 3;
	localparam int BIAS_W      = 2;
	localparam int ENTRY_W     = 24;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 24;

	localparam logic [BIAS_W-1:0]  BIAS_MAX        = 2'd2;
	localparam logic [BIAS_W-1:0]  BIAS_RESET      = 2'd1;
	localparam logic [ENTRY_W-1:0] ENTRY_RESET     = 24'd1;
	localparam logic [TOKEN_W-1:0] TOKEN_LAST      = 3'd7;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              first;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} out_item_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_BIAS = 1'b0,
		REG_ENTRY_SIZE = 1'b1
	} cfg_reg_e;

	typedef enum logic [2:0] {
		ST_FLAG,
		ST_TOKEN,
		ST_HIGH,
		ST_READ,
		ST_COPY
	} state_t;

	typedef struct packed {
		logic take;
		logic take_flag;
		logic take_lit;
		logic take_low;
		logic take_high;
		logic issue_read;
		logic emit_copy;
		logic token_next;
		logic token_clear;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic ent_zero;
		logic rem_zero;
		logic rem_one;
		logic tok_last;
		logic lit;
		logic len_one;
		logic slot_free;
	} sts_t;

endpackage

### rtl/core/lzss_ram.sv
// ----------------------------------------------------------------------------
// lzss_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds when no read is issued.
// ----------------------------------------------------------------------------
module lzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/lzss_ctrl.sv
// ----------------------------------------------------------------------------
// lzss_ctrl
// Token sequencer: tracks flag, token and match-word phases, and steps the
// datapath through the read and write cycles of each copied byte.
// ----------------------------------------------------------------------------
module lzss_ctrl
	import lzss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   in_state;
	logic   fire;

	assign in_state = (state_q == ST_FLAG) || (state_q == ST_TOKEN) || (state_q == ST_HIGH);
	assign in_ready = in_state && sts.slot_free;
	assign fire     = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FLAG, ST_TOKEN, ST_HIGH: begin
				if (fire) begin
					if (sts.first) begin
						state_d = sts.ent_zero ? ST_FLAG : ST_TOKEN;
					end else if (!sts.rem_zero) begin
						unique case (state_q)
							ST_TOKEN: begin
								if (!sts.lit) begin
									state_d = ST_HIGH;
								end else if (sts.rem_one || sts.tok_last) begin
									state_d = ST_FLAG;
								end else begin
									state_d = ST_TOKEN;
								end
							end
							ST_HIGH: state_d = ST_READ;
							default: state_d = ST_TOKEN;
						endcase
					end
				end
			end
			ST_READ: state_d = ST_COPY;
			ST_COPY: begin
				if (sts.slot_free) begin
					if (!sts.len_one) begin
						state_d = ST_READ;
					end else if (sts.rem_one || sts.tok_last) begin
						state_d = ST_FLAG;
					end else begin
						state_d = ST_TOKEN;
					end
				end
			end
			default: state_d = ST_FLAG;
		endcase
	end

	// command decode
	always_comb begin
		cmd = '0;
		cmd.take = fire;
		unique case (state_q)
			ST_FLAG, ST_TOKEN, ST_HIGH: begin
				if (fire) begin
					if (sts.first) begin
						cmd.take_flag = !sts.ent_zero;
					end else if (!sts.rem_zero) begin
						unique case (state_q)
							ST_TOKEN: begin
								cmd.take_lit    = sts.lit;
								cmd.take_low    = !sts.lit;
								cmd.token_clear = sts.lit && sts.rem_one;
								cmd.token_next  = sts.lit && !sts.rem_one;
							end
							ST_HIGH: cmd.take_high = 1'b1;
							default: cmd.take_flag = 1'b1;
						endcase
					end
				end
			end
			ST_READ: cmd.issue_read = 1'b1;
			ST_COPY: begin
				if (sts.slot_free) begin
					cmd.emit_copy   = 1'b1;
					cmd.token_clear = sts.len_one && sts.rem_one;
					cmd.token_next  = sts.len_one && !sts.rem_one;
				end
			end
			default: cmd = '0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FLAG;
		end else begin
			state_q <= state_d;
		end
	end

	a_copy_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY |-> $past(state_q) == ST_READ || $past(state_q) == ST_COPY)
		else $error("copy cycle without a preceding history read");

	a_no_input_in_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_COPY) |-> !in_ready)
		else $error("input taken while a copy is running");

	a_token_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.token_next && cmd.token_clear))
		else $error("token index advanced and cleared together");

endmodule

### rtl/core/lzss_dpath.sv
// ----------------------------------------------------------------------------
// lzss_dpath
// Datapath: configuration registers, decoder registers, history window,
// match address and length counters, and the output register.
// ----------------------------------------------------------------------------
module lzss_dpath
	import lzss_pkg::*;
#(
	parameter int WINDOW_DEPTH = 4096,
	parameter int SIZE_BITS    = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int WIN_AW = $clog2(WINDOW_DEPTH);

	logic [BIAS_W-1:0]    match_bias_q;
	logic [ENTRY_W-1:0]   entry_size_q;
	logic [WIN_AW-1:0]    wi_q;
	logic [WIN_AW-1:0]    rd_q;
	logic [SIZE_BITS-1:0] rem_q;
	logic [BYTE_W-1:0]    flags_q;
	logic [TOKEN_W-1:0]   tok_q;
	logic [BYTE_W-1:0]    off_q;
	logic [LEN_W-1:0]     len_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [SIZE_BITS-1:0] ent_sz;
	logic [2*BYTE_W-1:0]  word;
	logic [BIAS_W-1:0]    bias;
	logic [LEN_W-1:0]     len_raw;
	logic [LEN_W-1:0]     len_clamp;
	logic [DIST_W:0]      match_dist;
	logic                 emit;
	logic                 restart;
	logic [BYTE_W-1:0]    emit_byte;
	logic [BYTE_W-1:0]    ram_rdata;

	assign cfg_ready = 1'b1;
	assign ent_sz    = SIZE_BITS'(entry_size_q);

	// match word decode: length from the low nibble, distance from the rest
	assign word       = {in_data.in_byte, off_q};
	assign bias       = (match_bias_q > BIAS_MAX) ? BIAS_MAX : match_bias_q;
	assign len_raw    = LEN_W'(word[LEN_FIELD_W-1:0]) + LEN_W'(bias) + LEN_W'(1);
	assign len_clamp  = (rem_q < SIZE_BITS'(len_raw)) ? LEN_W'(rem_q) : len_raw;
	assign match_dist = (DIST_W+1)'(word[2*BYTE_W-1:LEN_FIELD_W]) + (DIST_W+1)'(1);

	assign emit      = cmd.take_lit || cmd.emit_copy;
	assign restart   = cmd.take && in_data.first;
	assign emit_byte = cmd.take_lit ? in_data.in_byte : ram_rdata;

	// status toward the controller
	assign sts.first     = in_data.first;
	assign sts.ent_zero  = (ent_sz == '0);
	assign sts.rem_zero  = (rem_q == '0);
	assign sts.rem_one   = (rem_q == SIZE_BITS'(1));
	assign sts.tok_last  = (tok_q == TOKEN_LAST);
	assign sts.lit       = flags_q[tok_q];
	assign sts.len_one   = (len_q == LEN_W'(1));
	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_bias_q <= BIAS_RESET;
			entry_size_q <= ENTRY_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_MATCH_BIAS: match_bias_q <= cfg_data[BIAS_W-1:0];
				REG_ENTRY_SIZE: entry_size_q <= cfg_data[ENTRY_W-1:0];
				default:        match_bias_q <= match_bias_q;
			endcase
		end
	end

	// decoder state, counters and window pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q    <= '0;
			rd_q    <= '0;
			rem_q   <= '0;
			flags_q <= '0;
			tok_q   <= '0;
			off_q   <= '0;
			len_q   <= '0;
		end else begin
			if (restart) begin
				rem_q <= ent_sz;
				off_q <= '0;
			end
			// load the flag byte; a restart into an empty entry clears it
			if (cmd.take_flag) begin
				flags_q <= in_data.in_byte;
			end else if (restart) begin
				flags_q <= '0;
			end
			if (cmd.take_low) begin
				off_q <= in_data.in_byte;
			end
			if (cmd.take_high) begin
				len_q <= len_clamp;
				rd_q  <= wi_q - WIN_AW'(match_dist);
			end
			if (cmd.issue_read) begin
				rd_q <= rd_q + WIN_AW'(1);
			end
			if (emit) begin
				wi_q  <= wi_q + WIN_AW'(1);
				rem_q <= rem_q - SIZE_BITS'(1);
			end
			if (cmd.emit_copy) begin
				len_q <= len_q - LEN_W'(1);
			end
			// rewind the token index on a new flag byte, a restart or entry end, else advance on token_next
			if (cmd.take_flag || cmd.token_clear || restart) begin
				tok_q <= '0;
			end else if (cmd.token_next) begin
				tok_q <= tok_q + TOKEN_W'(1);
			end
		end
	end

	// output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte <= emit_byte;
			out_q.last     <= (rem_q == SIZE_BITS'(1));
		end
	end

	// history window
	lzss_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(WINDOW_DEPTH)
	) u_history (
		.clk   (clk),
		.we    (emit),
		.waddr (wi_q),
		.wdata (emit_byte),
		.re    (cmd.issue_read),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> sts.slot_free)
		else $error("byte emitted over a result not yet taken");

	a_copy_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_copy |-> len_q != '0 && rem_q != '0)
		else $error("copy byte emitted with no length or entry left");

	a_last_ends_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> rem_q == '0)
		else $error("last byte pending while entry still owes bytes");

endmodule

### rtl/core/lzss_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS decompressor for 12-bit distance, 4-bit length streams with a
// 4096-byte history window, byte in, byte out.
// ----------------------------------------------------------------------------
// One compressed byte enters per input transaction, and only while the
// output register is free; a literal's byte is loaded into that register at
// the accepting edge. The two bytes of a match word are taken in ST_TOKEN and
// ST_HIGH. Each copied byte, 1 to 18 per match, then gets a registered read
// of the history RAM in ST_READ and is emitted and written back in ST_COPY,
// so overlapping copies see their own output; the input is held during the
// copy. Setting first on a byte restarts the entry; bytes after the entry's
// last output are dropped. The history window is not cleared: copies must
// only reach bytes already produced since reset. Write match_bias and
// entry_size only while idle.
module lzss_stream_decompressor
	import lzss_pkg::*;
#(
	parameter int WINDOW_DEPTH = 4096,
	parameter int SIZE_BITS    = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	lzss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzss_dpath #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SIZE_BITS   (SIZE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
